// File: hdl/bpfa_pkg.sv
`default_nettype none
package bpfa_pkg;

  localparam int NumPages   = 4096;
  localparam int PageBits   = $clog2(NumPages);
  localparam int CountBits  = 13;
  localparam int WordBits   = 32;
  localparam int NumWords   = NumPages / WordBits;
  localparam int WordAddrBits = $clog2(NumWords);
  localparam int BitSelBits = $clog2(WordBits);
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [CountBits-1:0] ManagedReset = CountBits'(NumPages);

  typedef enum logic [2:0] {
    CMD_ALLOC_ONE = 3'd0,
    CMD_ALLOC_RUN = 3'd1,
    CMD_FREE      = 3'd2,
    CMD_LOCK      = 3'd3,
    CMD_RESERVE   = 3'd4,
    CMD_UNRESERVE = 3'd5
  } cmd_t;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_PAGE = 2'd1;
  localparam logic [1:0] STATUS_ZERO    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_TOUCH_RD,
    ST_TOUCH_WR,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: hdl/bpfa_bitmap_ram.sv
`default_nettype none
module bpfa_bitmap_ram
  import bpfa_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [WordAddrBits-1:0] waddr,
  input  wire logic [WordBits-1:0]     wdata,
  input  wire logic [WordAddrBits-1:0] raddr,
  output logic      [WordBits-1:0]     rdata
);

  logic [WordBits-1:0] mem [NumWords];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/bitmap_page_frame_allocator_unit.sv
`default_nettype none
// Channel     | Ports                                           | Handshake
// ------------+-------------------------------------------------+--------------------------
// config      | managed_pages_we, managed_pages_wdata           | written when we is high
// command in  | cmd, page_index, page_count                     | start high, busy low
// result out  | status, result_page, free_pages, used_pages,    | done strobe, one cycle
//             | reserved_pages                                  |
//
// The bitmap lives in a 128 x 32 synchronous RAM. After reset a clearing pass
// zeroes it one word per cycle while busy stays high.
// An allocation scans pages from the hint, each with a read step, then a check step.
// Every page that a command touches goes through a read state, then a write state.
// The receiver cannot stall; each result is flagged by done for one cycle, and
// status and result_page hold until the next command is taken.
module bitmap_page_frame_allocator_unit
  import bpfa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 managed_pages_we,
  input  wire logic [CountBits-1:0] managed_pages_wdata,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [2:0]           cmd,
  input  wire logic [PageBits-1:0]  page_index,
  input  wire logic [CountBits-1:0] page_count,
  output logic                      done,
  output logic [1:0]                status,
  output logic [PageBits-1:0]       result_page,
  output logic [CountBits-1:0]      free_pages,
  output logic [CountBits-1:0]      used_pages,
  output logic [CountBits-1:0]      reserved_pages
);

  state_t state, state_next;

  logic [CountBits-1:0] managed, hint, free_cnt, used_cnt, rsv_cnt;
  logic [2:0]           op;
  logic [CountBits-1:0] need, remaining, run_start;
  // Page cursor, one bit wider so it can pass the end of the bitmap.
  logic [CountBits:0]   cur;
  logic [CountBits-1:0] left;
  logic [WordAddrBits-1:0] clr_addr;

  logic                    ram_we;
  logic [WordAddrBits-1:0] ram_waddr, ram_raddr;
  logic [WordBits-1:0]     ram_wdata, ram_rdata;

  bpfa_bitmap_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [CountBits-1:0] wr_value;
  logic                 cur_bit, cur_in_range, set_op;
  logic [BitSelBits-1:0] bsel;

  assign bsel         = cur[BitSelBits-1:0];
  assign cur_bit      = ram_rdata[bsel];
  assign cur_in_range = cur < {1'b0, managed};
  assign set_op       = (op == CMD_LOCK) || (op == CMD_RESERVE) ||
                        (op == CMD_ALLOC_ONE) || (op == CMD_ALLOC_RUN);
  assign wr_value     = (managed_pages_wdata > ManagedReset) ? ManagedReset
                                                             : managed_pages_wdata;
  assign busy         = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cur[PageBits-1:BitSelBits];
    ram_wdata  = ram_rdata;
    ram_raddr  = cur[PageBits-1:BitSelBits];
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd == CMD_ALLOC_ONE || cmd == CMD_ALLOC_RUN) begin
            state_next = ((cmd == CMD_ALLOC_RUN) && (page_count == '0)) ? ST_DONE
                                                                         : ST_SCAN_RD;
          end else if (cmd inside {CMD_FREE, CMD_LOCK, CMD_RESERVE, CMD_UNRESERVE} &&
                       page_count != '0) begin
            state_next = ST_TOUCH_RD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == WordAddrBits'(NumWords - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        state_next = cur_in_range ? ST_SCAN_CHK : ST_DONE;
      end
      ST_SCAN_CHK: begin
        if (!cur_bit && remaining == CountBits'(1)) begin
          state_next = ST_TOUCH_RD;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_TOUCH_RD: begin
        state_next = ST_TOUCH_WR;
      end
      ST_TOUCH_WR: begin
        if (cur_in_range && (cur_bit != set_op)) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          ram_wdata[bsel] = set_op;
        end
        state_next = (left == CountBits'(1)) ? ST_DONE : ST_TOUCH_RD;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      managed  <= ManagedReset;
      hint     <= '0;
      free_cnt <= ManagedReset;
      used_cnt <= '0;
      rsv_cnt  <= '0;
      clr_addr <= '0;
      done     <= 1'b0;
      status   <= STATUS_OK;
    end else begin
      done <= 1'b0;
      if (managed_pages_we) begin
        managed  <= wr_value;
        free_cnt <= wr_value;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: begin
          if (start) begin
            op          <= cmd;
            status      <= STATUS_OK;
            result_page <= '0;
            need        <= (cmd == CMD_ALLOC_ONE) ? CountBits'(1) : page_count;
            remaining   <= (cmd == CMD_ALLOC_ONE) ? CountBits'(1) : page_count;
            run_start   <= hint;
            left        <= page_count;
            if (cmd == CMD_ALLOC_ONE || cmd == CMD_ALLOC_RUN) begin
              cur <= {1'b0, hint};
              if (cmd == CMD_ALLOC_RUN && page_count == '0) begin
                status <= STATUS_ZERO;
              end
            end else begin
              cur <= {2'b00, page_index};
            end
          end
        end
        ST_SCAN_RD: begin
          if (!cur_in_range) begin
            status <= STATUS_NO_PAGE;
            hint   <= managed;
          end
        end
        ST_SCAN_CHK: begin
          if (!cur_bit) begin
            remaining <= remaining - 1'b1;
            if (remaining == CountBits'(1)) begin
              // Run found: hint stays on its last page, then mark from its start.
              hint        <= cur[CountBits-1:0];
              cur         <= {1'b0, run_start};
              left        <= need;
              op          <= CMD_LOCK;
              result_page <= run_start[PageBits-1:0];
            end else begin
              cur <= cur + 1'b1;
            end
          end else begin
            remaining <= need;
            run_start <= cur[CountBits-1:0] + 1'b1;
            cur       <= cur + 1'b1;
          end
        end
        ST_TOUCH_WR: begin
          if (cur_in_range && (cur_bit != set_op)) begin
            if (set_op) begin
              free_cnt <= (free_cnt == '0) ? '0 : free_cnt - 1'b1;
              if (op == CMD_LOCK) begin
                used_cnt <= (used_cnt == CountMax) ? CountMax : used_cnt + 1'b1;
              end else begin
                rsv_cnt <= (rsv_cnt == CountMax) ? CountMax : rsv_cnt + 1'b1;
              end
            end else begin
              free_cnt <= (free_cnt == CountMax) ? CountMax : free_cnt + 1'b1;
              if (op == CMD_FREE) begin
                used_cnt <= (used_cnt == '0) ? '0 : used_cnt - 1'b1;
              end else begin
                rsv_cnt <= (rsv_cnt == '0) ? '0 : rsv_cnt - 1'b1;
              end
              if (hint > cur[CountBits-1:0]) begin
                hint <= cur[CountBits-1:0];
              end
            end
          end
          cur  <= cur + 1'b1;
          left <= left - 1'b1;
        end
        ST_DONE: begin
          done <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign free_pages     = free_cnt;
  assign used_pages     = used_cnt;
  assign reserved_pages = rsv_cnt;

endmodule
`default_nettype wire
